// File: rtl/rbph_pkg.sv
// ----------------------------------------------------------------------------
// rbph_pkg - shared types and constants of the ring buffer pool
// Sizes, command codes, result layout and small helper functions.
// ----------------------------------------------------------------------------
package rbph_pkg;

  // Pool geometry
  localparam int BUF_DEPTH    = 64;
  localparam int POOL_COUNT   = 4;
  localparam int ID_LIMIT     = 4;
  localparam int CREATE_LIMIT = (POOL_COUNT < ID_LIMIT) ? POOL_COUNT : ID_LIMIT;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 2;
  localparam int BYTE_W = 8;
  localparam int OFS_W  = 6;

  // Derived widths
  localparam int PTR_W  = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int POOL_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int ADDR_W = $clog2(POOL_COUNT * BUF_DEPTH);
  localparam int MEM_DEPTH = POOL_COUNT * BUF_DEPTH;

  // Stream packing
  localparam int IN_FIELDS_W  = ID_W + BYTE_W + 2 * OFS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + ID_W + BYTE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int IN_ID_LSB   = 0;
  localparam int IN_BYTE_LSB = IN_ID_LSB + ID_W;
  localparam int IN_FROM_LSB = IN_BYTE_LSB + BYTE_W;
  localparam int IN_TO_LSB   = IN_FROM_LSB + OFS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE      = 3'd0,
    CMD_DESTROY     = 3'd1,
    CMD_ADD         = 3'd2,
    CMD_GET         = 3'd3,
    CMD_DESTROY_ALL = 3'd4
  } cmd_t;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              ok;
    logic [ID_W-1:0]   granted_id;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } res_t;

  // Output queue status seen by the sequencer
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } obuf_stat_t;

  typedef logic [PTR_W-1:0] ofs_tbl_t [2**OFS_W];

  // Offset field reduced modulo the buffer depth, built at elaboration
  function automatic ofs_tbl_t build_mod_tbl();
    ofs_tbl_t t;
    for (int i = 0; i < 2**OFS_W; i++) begin
      t[i] = PTR_W'(i % BUF_DEPTH);
    end
    return t;
  endfunction

  localparam ofs_tbl_t MOD_TBL = build_mod_tbl();

  // Advance a buffer position with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(BUF_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // a - b modulo the buffer depth, both operands below the depth
  function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0] a,
                                               input logic [PTR_W-1:0] b);
    logic [PTR_W:0] r;
    if (a >= b) begin
      r = {1'b0, a} - {1'b0, b};
    end else begin
      r = {1'b0, a} + (PTR_W + 1)'(BUF_DEPTH) - {1'b0, b};
    end
    return r[PTR_W-1:0];
  endfunction

  // Flat store address of one place of one buffer
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [POOL_W-1:0] slot,
                                                 input logic [PTR_W-1:0]  pos);
    return ADDR_W'(slot) * ADDR_W'(BUF_DEPTH) + ADDR_W'(pos);
  endfunction

endpackage

// File: rtl/ring_buffer_pool_history_unit.sv
// ----------------------------------------------------------------------------
// ring_buffer_pool_history_unit - pool of byte ring buffers with read-back
// Create, destroy, append and windowed history reads over stream ports.
// ----------------------------------------------------------------------------
// Timing: create, destroy, destroy-all and add are each done on acceptance, and
// the next request is taken as soon as the result queue has room (create's reply
// waits in the result queue). A get of n bytes, n = (from_back - to_back) mod 64
// or 64 when the two match, streams its bytes at up to one per cycle, set by the
// single read port of the byte store and held back while the result queue is
// full; the next request is taken once the final read lands. The store needs no
// clearing pass: a per-buffer fill count marks which places were written since
// the buffer was last cleared, and places beyond it read as zero. Results leave
// through a two-entry queue, so the output side may stall without losing a byte.
module ring_buffer_pool_history_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] buffer_id, [9:2] data_byte, [15:10] from_back, [21:16] to_back
  input  logic [rbph_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] cmd
  input  logic [rbph_pkg::CMD_W-1:0]         in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] ok, [2:1] granted_id, [10:3] out_byte
  output logic [rbph_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] kind
  output logic                               out_tuser,
  output logic                               out_tlast
);

  logic                             mem_we;
  logic [rbph_pkg::ADDR_W-1:0]      mem_waddr;
  logic [rbph_pkg::BYTE_W-1:0]      mem_wdata;
  logic                             mem_re;
  logic [rbph_pkg::ADDR_W-1:0]      mem_raddr;
  logic [rbph_pkg::BYTE_W-1:0]      mem_rdata;
  logic                             push;
  rbph_pkg::res_t                   push_res;
  rbph_pkg::res_t                   out_res;
  rbph_pkg::obuf_stat_t             ob_stat;

  // unpack the request fields
  logic [rbph_pkg::ID_W-1:0]        req_id;
  logic [rbph_pkg::BYTE_W-1:0]      req_byte;
  logic [rbph_pkg::OFS_W-1:0]       req_from;
  logic [rbph_pkg::OFS_W-1:0]       req_to;

  assign req_id   = in_tdata[rbph_pkg::IN_ID_LSB   +: rbph_pkg::ID_W];
  assign req_byte = in_tdata[rbph_pkg::IN_BYTE_LSB +: rbph_pkg::BYTE_W];
  assign req_from = in_tdata[rbph_pkg::IN_FROM_LSB +: rbph_pkg::OFS_W];
  assign req_to   = in_tdata[rbph_pkg::IN_TO_LSB   +: rbph_pkg::OFS_W];

  rbph_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_id     (req_id),
    .in_byte   (req_byte),
    .in_from   (req_from),
    .in_to     (req_to),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .push      (push),
    .push_res  (push_res),
    .ob_stat   (ob_stat)
  );

  // byte store: every buffer back to back
  rbph_ram #(
    .DATA_W (rbph_pkg::BYTE_W),
    .DEPTH  (rbph_pkg::MEM_DEPTH),
    .ADDR_W (rbph_pkg::ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rbph_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .stat      (ob_stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pack the result, zero filled to whole bytes
  assign out_tdata = rbph_pkg::OUT_TDATA_W'({out_res.out_byte, out_res.granted_id,
                                             out_res.ok});
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

// File: rtl/rbph_ram.sv
// ----------------------------------------------------------------------------
// rbph_ram - simple dual-port synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rbph_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rbph_obuf.sv
// ----------------------------------------------------------------------------
// rbph_obuf - two-entry result queue
// Parts the sequencer from the output stream so reads can run ahead.
// ----------------------------------------------------------------------------
module rbph_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rbph_pkg::res_t      push_res,
  output rbph_pkg::obuf_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output rbph_pkg::res_t      out_res
);

  rbph_pkg::res_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           pop;

  assign out_valid  = (count_r != 2'd0);
  assign out_res    = q_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  assign stat.count = count_r;
  assign stat.pop   = pop;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_res;
    end
  end

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != 2'd2 || pop))
    else $error("result queue overflow");

endmodule

// File: rtl/rbph_seq.sv
// ----------------------------------------------------------------------------
// rbph_seq - command sequencer and buffer table
// Decodes requests, keeps per-buffer state and drives the byte store.
// ----------------------------------------------------------------------------
module rbph_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rbph_pkg::CMD_W-1:0]      in_cmd,
  input  logic [rbph_pkg::ID_W-1:0]       in_id,
  input  logic [rbph_pkg::BYTE_W-1:0]     in_byte,
  input  logic [rbph_pkg::OFS_W-1:0]      in_from,
  input  logic [rbph_pkg::OFS_W-1:0]      in_to,
  output logic                            mem_we,
  output logic [rbph_pkg::ADDR_W-1:0]     mem_waddr,
  output logic [rbph_pkg::BYTE_W-1:0]     mem_wdata,
  output logic                            mem_re,
  output logic [rbph_pkg::ADDR_W-1:0]     mem_raddr,
  input  logic [rbph_pkg::BYTE_W-1:0]     mem_rdata,
  output logic                            push,
  output rbph_pkg::res_t                  push_res,
  input  rbph_pkg::obuf_stat_t            ob_stat
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_GET  = 2'b10
  } state_t;

  state_t                         st_r, st_nxt;
  logic                           in_use_r   [rbph_pkg::POOL_COUNT];
  logic                           in_use_nxt [rbph_pkg::POOL_COUNT];
  logic [rbph_pkg::PTR_W-1:0]     wp_r       [rbph_pkg::POOL_COUNT];
  logic [rbph_pkg::PTR_W-1:0]     wp_nxt     [rbph_pkg::POOL_COUNT];
  logic [rbph_pkg::CNT_W-1:0]     fill_r     [rbph_pkg::POOL_COUNT];
  logic [rbph_pkg::CNT_W-1:0]     fill_nxt   [rbph_pkg::POOL_COUNT];
  logic [rbph_pkg::POOL_W-1:0]    slot_r, slot_nxt;
  logic [rbph_pkg::PTR_W-1:0]     pos_r, pos_nxt;
  logic [rbph_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic                           rvalid_r, rlast_r, rzero_r;

  logic                           accept;
  logic                           id_ok;
  logic [rbph_pkg::POOL_W-1:0]    slot_in;
  logic                           found;
  logic [rbph_pkg::POOL_W-1:0]    free_slot;
  logic                           space_ok;
  logic                           rd_last;
  logic                           rd_zero;
  logic [rbph_pkg::PTR_W-1:0]     from_m, to_m;
  logic                           create_push;
  rbph_pkg::res_t                 create_res;
  rbph_pkg::res_t                 byte_res;

  assign slot_in   = rbph_pkg::POOL_W'(in_id);
  assign id_ok     = (int'(in_id) < rbph_pkg::POOL_COUNT);
  assign in_tready = (st_r == ST_IDLE) && !rvalid_r && (ob_stat.count != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign from_m    = rbph_pkg::MOD_TBL[in_from];
  assign to_m      = rbph_pkg::MOD_TBL[in_to];

  // lowest free buffer that create may claim
  always_comb begin
    found     = 1'b0;
    free_slot = '0;
    for (int i = rbph_pkg::CREATE_LIMIT - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        found     = 1'b1;
        free_slot = rbph_pkg::POOL_W'(i);
      end
    end
  end

  // room in the queue for a read issued now, counting the one landing
  assign space_ok = ({1'b0, ob_stat.count} + 3'(rvalid_r)) < (3'd2 + 3'(ob_stat.pop));
  assign mem_re    = (st_r == ST_GET) && space_ok;
  assign mem_raddr = rbph_pkg::mem_addr(slot_r, pos_r);
  assign rd_last   = (rem_r == rbph_pkg::CNT_W'(1));
  assign rd_zero   = !(rbph_pkg::CNT_W'(pos_r) < fill_r[slot_r]);

  always_comb begin
    st_nxt      = st_r;
    in_use_nxt  = in_use_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    slot_nxt    = slot_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    mem_we      = 1'b0;
    mem_waddr   = rbph_pkg::mem_addr(slot_in, wp_r[slot_in]);
    mem_wdata   = in_byte;
    create_push = 1'b0;
    create_res  = '0;
    create_res.kind = rbph_pkg::KIND_CREATE;

    if (accept) begin
      unique case (rbph_pkg::cmd_t'(in_cmd))
        rbph_pkg::CMD_CREATE: begin
          create_push = 1'b1;
          if (found) begin
            in_use_nxt[free_slot] = 1'b1;
            wp_nxt[free_slot]     = '0;
            fill_nxt[free_slot]   = '0;
            create_res.ok         = 1'b1;
            create_res.granted_id = rbph_pkg::ID_W'(free_slot);
          end
        end
        rbph_pkg::CMD_DESTROY: begin
          if (id_ok) begin
            in_use_nxt[slot_in] = 1'b0;
            wp_nxt[slot_in]     = '0;
            fill_nxt[slot_in]   = '0;
          end
        end
        rbph_pkg::CMD_ADD: begin
          if (id_ok && in_use_r[slot_in]) begin
            mem_we          = 1'b1;
            wp_nxt[slot_in] = rbph_pkg::ptr_inc(wp_r[slot_in]);
            if (fill_r[slot_in] != rbph_pkg::CNT_W'(rbph_pkg::BUF_DEPTH)) begin
              fill_nxt[slot_in] = fill_r[slot_in] + 1'b1;
            end
          end
        end
        rbph_pkg::CMD_GET: begin
          if (id_ok && in_use_r[slot_in]) begin
            st_nxt   = ST_GET;
            slot_nxt = slot_in;
            pos_nxt  = rbph_pkg::ptr_sub(wp_r[slot_in], from_m);
            if (from_m == to_m) begin
              rem_nxt = rbph_pkg::CNT_W'(rbph_pkg::BUF_DEPTH);
            end else begin
              rem_nxt = rbph_pkg::CNT_W'(rbph_pkg::ptr_sub(from_m, to_m));
            end
          end
        end
        rbph_pkg::CMD_DESTROY_ALL: begin
          for (int i = 0; i < rbph_pkg::POOL_COUNT; i++) begin
            in_use_nxt[i] = 1'b0;
            wp_nxt[i]     = '0;
            fill_nxt[i]   = '0;
          end
        end
        default: begin
        end
      endcase
    end

    // walk the window one place per issued read
    if (mem_re) begin
      pos_nxt = rbph_pkg::ptr_inc(pos_r);
      rem_nxt = rem_r - 1'b1;
      if (rd_last) begin
        st_nxt = ST_IDLE;
      end
    end
  end

  always_comb begin
    byte_res            = '0;
    byte_res.kind       = rbph_pkg::KIND_BYTE;
    byte_res.out_byte   = rzero_r ? '0 : mem_rdata;
    byte_res.last       = rlast_r;
  end

  // read data and create replies never meet: requests wait for reads to land
  assign push     = rvalid_r || create_push;
  assign push_res = rvalid_r ? byte_res : create_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      rvalid_r <= 1'b0;
      for (int i = 0; i < rbph_pkg::POOL_COUNT; i++) begin
        in_use_r[i] <= 1'b0;
        wp_r[i]     <= '0;
        fill_r[i]   <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      rvalid_r <= mem_re;
      in_use_r <= in_use_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    pos_r   <= pos_nxt;
    rem_r   <= rem_nxt;
    rlast_r <= rd_last;
    rzero_r <= rd_zero;
  end

  // a run in progress always has bytes left
  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_GET) |-> (rem_r != '0))
    else $error("get run with no bytes left");

  // the final read closes the run
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && rd_last) |=> (st_r == ST_IDLE && rvalid_r && rlast_r))
    else $error("get run did not close on its final read");

  // until a buffer wraps, its write index equals its fill count
  for (genvar g = 0; g < rbph_pkg::POOL_COUNT; g++) begin : g_fill_chk
    a_fill_wp: assert property (@(posedge clk) disable iff (!rst_n)
      (fill_r[g] != rbph_pkg::CNT_W'(rbph_pkg::BUF_DEPTH))
        |-> (rbph_pkg::CNT_W'(wp_r[g]) == fill_r[g]))
      else $error("write index and fill count disagree");
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - request/result check of the ring buffer pool history unit
// Feeds create, destroy, add, get and destroy-all requests (plus unknown
// codes) over the request stream, predicts every create reply and window
// byte from a local copy of the pool, and checks results in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  // Unused command codes, all ignored by the block
  localparam logic [rbph_pkg::CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [rbph_pkg::CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

  localparam int RANDOM_ITEMS   = 236;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 150;
  localparam int MAX_PRINTS     = 40;

  typedef struct {
    logic [rbph_pkg::CMD_W-1:0]  cmd;
    logic [rbph_pkg::ID_W-1:0]   id;
    logic [rbph_pkg::BYTE_W-1:0] data;
    logic [rbph_pkg::OFS_W-1:0]  from_back;
    logic [rbph_pkg::OFS_W-1:0]  to_back;
    int                          gap;   // idle cycles before the request is offered
    bit                          hold;  // wait until no result is outstanding first
  } request_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  // [1:0] buffer_id, [9:2] data_byte, [15:10] from_back, [21:16] to_back
  logic [rbph_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  // [2:0] cmd
  logic [rbph_pkg::CMD_W-1:0]       in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [0] ok, [2:1] granted_id, [10:3] out_byte
  logic [rbph_pkg::OUT_TDATA_W-1:0] out_tdata;
  // [0] kind
  logic                             out_tuser;
  logic                             out_tlast;

  // Requests still to be offered, and results owed by the block
  request_t       requests_todo[$];
  request_t       req_on_bus;
  rbph_pkg::res_t replies_due[$];

  // Local copy of the pool, advanced at each accepted request
  bit                          pool_live [rbph_pkg::POOL_COUNT];
  logic [rbph_pkg::PTR_W-1:0]  pool_wp   [rbph_pkg::POOL_COUNT];
  logic [rbph_pkg::BYTE_W-1:0] pool_mem  [rbph_pkg::MEM_DEPTH];

  // Generator-side view of which buffers are claimed, to build sensible sequences
  bit [rbph_pkg::POOL_COUNT-1:0] gen_live = '0;
  bit                            gen_quiet = 1'b0;

  int errors      = 0;
  int results_in  = 0;
  int gap_count   = 0;
  int stall_left  = 0;
  int quiet_left  = 0;
  int idle_cycles = 0;
  logic [rbph_pkg::IN_TDATA_W-1:0] tdata_next;
  rbph_pkg::res_t seen;
  rbph_pkg::res_t due;

  ring_buffer_pool_history_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("ERROR result %0d: %s got %0h want %0h", results_in, what, got, want);
    end
  endtask

  // Free a buffer: zero its write index and its store
  function automatic void clear_slot(input int id);
    pool_live[id] = 1'b0;
    pool_wp[id]   = '0;
    for (int p = 0; p < rbph_pkg::BUF_DEPTH; p++) begin
      pool_mem[id * rbph_pkg::BUF_DEPTH + p] = '0;
    end
  endfunction

  // Advance the local pool by one accepted request and queue what it owes
  function automatic void predict_replies(input request_t r);
    rbph_pkg::res_t rep;
    int   id, fb, tb, s, e, n, pos;
    bit   found;
    id    = int'(r.id);
    fb    = int'(r.from_back) % rbph_pkg::BUF_DEPTH;
    tb    = int'(r.to_back) % rbph_pkg::BUF_DEPTH;
    found = 1'b0;
    rep   = '0;
    case (r.cmd)
      rbph_pkg::CMD_CREATE: begin
        // Claim the lowest free buffer; a full pool still answers, with ok low
        rep.kind = rbph_pkg::KIND_CREATE;
        for (int i = 0; i < rbph_pkg::CREATE_LIMIT && !found; i++) begin
          if (!pool_live[i]) begin
            clear_slot(i);
            pool_live[i]   = 1'b1;
            rep.ok         = 1'b1;
            rep.granted_id = rbph_pkg::ID_W'(i);
            found          = 1'b1;
          end
        end
        replies_due.push_back(rep);
      end
      rbph_pkg::CMD_DESTROY: begin
        // Clears even a buffer that is already free
        if (id < rbph_pkg::POOL_COUNT) clear_slot(id);
      end
      rbph_pkg::CMD_ADD: begin
        if (id < rbph_pkg::POOL_COUNT && pool_live[id]) begin
          pool_mem[id * rbph_pkg::BUF_DEPTH + int'(pool_wp[id])] = r.data;
          pool_wp[id] = rbph_pkg::PTR_W'((int'(pool_wp[id]) + 1) % rbph_pkg::BUF_DEPTH);
        end
      end
      rbph_pkg::CMD_GET: begin
        if (id < rbph_pkg::POOL_COUNT && pool_live[id]) begin
          s = (int'(pool_wp[id]) + rbph_pkg::BUF_DEPTH - fb) % rbph_pkg::BUF_DEPTH;
          e = (int'(pool_wp[id]) + rbph_pkg::BUF_DEPTH - tb) % rbph_pkg::BUF_DEPTH;
          n = (e + rbph_pkg::BUF_DEPTH - s) % rbph_pkg::BUF_DEPTH;
          // Matching start and end read the whole buffer
          if (n == 0) n = rbph_pkg::BUF_DEPTH;
          pos = s;
          for (int k = 0; k < n; k++) begin
            rep          = '0;
            rep.kind     = rbph_pkg::KIND_BYTE;
            rep.out_byte = pool_mem[id * rbph_pkg::BUF_DEPTH + pos];
            rep.last     = (k == n - 1);
            replies_due.push_back(rep);
            pos = (pos + 1) % rbph_pkg::BUF_DEPTH;
          end
        end
      end
      rbph_pkg::CMD_DESTROY_ALL: begin
        for (int i = 0; i < rbph_pkg::POOL_COUNT; i++) clear_slot(i);
      end
      default: begin
      end
    endcase
  endfunction

  // Append a request to the stimulus and track claims on the generator side
  function automatic void queue_request(input logic [rbph_pkg::CMD_W-1:0] cmd,
                                        input logic [31:0] id,
                                        input logic [31:0] data,
                                        input logic [31:0] fb,
                                        input logic [31:0] tb,
                                        input bit hold);
    request_t r;
    bit       found;
    r.cmd       = cmd;
    r.id        = rbph_pkg::ID_W'(id);
    r.data      = rbph_pkg::BYTE_W'(data);
    r.from_back = rbph_pkg::OFS_W'(fb);
    r.to_back   = rbph_pkg::OFS_W'(tb);
    r.gap       = gen_quiet ? 0 : pick_gap();
    r.hold      = hold;
    requests_todo.push_back(r);
    found = 1'b0;
    case (cmd)
      rbph_pkg::CMD_CREATE: begin
        for (int i = 0; i < rbph_pkg::CREATE_LIMIT && !found; i++) begin
          if (!gen_live[i]) begin
            gen_live[i] = 1'b1;
            found       = 1'b1;
          end
        end
      end
      rbph_pkg::CMD_DESTROY:     gen_live[r.id] = 1'b0;
      rbph_pkg::CMD_DESTROY_ALL: gen_live = '0;
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_live_id();
    int ids[$];
    for (int i = 0; i < rbph_pkg::POOL_COUNT; i++) begin
      if (gen_live[i]) ids.push_back(i);
    end
    if (ids.size() == 0) return $urandom_range(0, rbph_pkg::POOL_COUNT - 1);
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // Stimulus, reset release and end of run
  initial begin
    int r, n, fb, tb;
    // Directed: free-buffer requests, full-buffer reads, pool exhaustion,
    // destroy of a free buffer, unknown codes and destroy-all
    queue_request(rbph_pkg::CMD_GET, 0, $urandom, 5, 1, 1'b0);
    queue_request(rbph_pkg::CMD_ADD, 1, 'h3C, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_CREATE, $urandom, $urandom, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_GET, 0, $urandom, 0, 0, 1'b0);
    queue_request(rbph_pkg::CMD_ADD, 0, 'hFF, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_ADD, 0, 'h00, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_ADD, 0, 'hA5, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_GET, 0, $urandom, 3, 0, 1'b1);
    queue_request(rbph_pkg::CMD_GET, 0, $urandom, 63, 63, 1'b0);
    queue_request(rbph_pkg::CMD_GET, 0, $urandom, 0, 63, 1'b0);
    for (int i = 0; i < 4; i++) begin
      queue_request(rbph_pkg::CMD_CREATE, $urandom, $urandom, $urandom, $urandom, 1'b0);
    end
    queue_request(rbph_pkg::CMD_ADD, 3, 'h5A, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_GET, 3, $urandom, 1, 0, 1'b0);
    queue_request(rbph_pkg::CMD_DESTROY, 2, $urandom, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_CREATE, $urandom, $urandom, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_DESTROY, 2, $urandom, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_DESTROY, 2, $urandom, $urandom, $urandom, 1'b0);
    queue_request(CMD_BAD_FIRST, $urandom, $urandom, $urandom, $urandom, 1'b0);
    queue_request(CMD_BAD_LAST, $urandom, $urandom, $urandom, $urandom, 1'b0);
    queue_request(rbph_pkg::CMD_DESTROY_ALL, $urandom, $urandom, $urandom, $urandom, 1'b1);
    queue_request(rbph_pkg::CMD_GET, 0, $urandom, 7, 2, 1'b0);
    queue_request(rbph_pkg::CMD_CREATE, $urandom, $urandom, $urandom, $urandom, 1'b0);

    // Random: mostly well-formed use of claimed buffers, some noise
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // Every so often run a stretch with no sender gaps at all
      if (k % 20 == 0) gen_quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      // Nothing claimed: mostly claim one before anything else
      if (gen_live == '0 && r >= 10 && r < 85) r = 0;
      if (r < 8) begin
        queue_request(rbph_pkg::CMD_CREATE, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 49) == 0);
      end else if (r < 12) begin
        queue_request(rbph_pkg::CMD_DESTROY, pick_live_id(), $urandom, $urandom,
                      $urandom, 1'b0);
      end else if (r < 17) begin
        // Burst of adds into one buffer so that its index may wrap
        n  = $urandom_range(20, 70);
        if (n > RANDOM_ITEMS - k) n = RANDOM_ITEMS - k;
        fb = pick_live_id();
        for (int j = 0; j < n; j++) begin
          queue_request(rbph_pkg::CMD_ADD, fb, $urandom, $urandom, $urandom, 1'b0);
        end
        k += n - 1;
      end else if (r < 55) begin
        queue_request(rbph_pkg::CMD_ADD, pick_live_id(), $urandom, $urandom, $urandom,
                      1'b0);
      end else if (r < 82) begin
        fb = $urandom_range(0, rbph_pkg::BUF_DEPTH - 1);
        case ($urandom_range(0, 3))
          0:       tb = fb;
          1:       tb = (fb + rbph_pkg::BUF_DEPTH - $urandom_range(1, 6))
                        % rbph_pkg::BUF_DEPTH;
          default: tb = $urandom_range(0, rbph_pkg::BUF_DEPTH - 1);
        endcase
        queue_request(rbph_pkg::CMD_GET, pick_live_id(), $urandom, fb, tb,
                      $urandom_range(0, 49) == 0);
      end else if (r < 85) begin
        queue_request(rbph_pkg::CMD_DESTROY_ALL, $urandom, $urandom, $urandom, $urandom,
                      1'b0);
      end else if (r < 93) begin
        // Noise: any buffer, claimed or not
        queue_request($urandom_range(0, 1) ? rbph_pkg::CMD_ADD : rbph_pkg::CMD_GET,
                      $urandom, $urandom, $urandom, $urandom, 1'b0);
      end else begin
        queue_request(CMD_BAD_FIRST +
                      rbph_pkg::CMD_W'($urandom_range(0, CMD_BAD_LAST - CMD_BAD_FIRST)),
                      $urandom, $urandom, $urandom, $urandom, 1'b0);
      end
    end

    // Hold reset, then release it once
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all requests offered and taken, then all results back
    while (requests_todo.size() != 0 || in_tvalid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    // Keep watching for stray results a while longer
    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      report_error("results never arrived", replies_due.size(), 0);
    end
    if (errors == 0) begin
      $display("ring_buffer_pool_history_unit: match");
    end else begin
      $display("ring_buffer_pool_history_unit: mismatch");
    end
    $finish;
  end

  // Request driver: predict on acceptance, then offer the next request after
  // its gap; a held request waits until every owed result has come back
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_count = 0;
    end else begin
      if (in_tvalid && in_tready) predict_replies(req_on_bus);
      if (!in_tvalid || in_tready) begin
        if (requests_todo.size() != 0 && gap_count < requests_todo[0].gap) begin
          gap_count++;
          in_tvalid <= 1'b0;
        end else if (requests_todo.size() != 0 &&
                     !(requests_todo[0].hold && replies_due.size() != 0)) begin
          req_on_bus = requests_todo.pop_front();
          gap_count  = 0;
          tdata_next = '0;
          tdata_next[rbph_pkg::IN_ID_LSB   +: rbph_pkg::ID_W]   = req_on_bus.id;
          tdata_next[rbph_pkg::IN_BYTE_LSB +: rbph_pkg::BYTE_W] = req_on_bus.data;
          tdata_next[rbph_pkg::IN_FROM_LSB +: rbph_pkg::OFS_W]  = req_on_bus.from_back;
          tdata_next[rbph_pkg::IN_TO_LSB   +: rbph_pkg::OFS_W]  = req_on_bus.to_back;
          in_tdata  <= tdata_next;
          in_tuser  <= req_on_bus.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest one owed,
  // and stall the result side at random, with occasional stall-free stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      quiet_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.kind       = out_tuser;
        seen.ok         = out_tdata[0];
        seen.granted_id = out_tdata[2:1];
        seen.out_byte   = out_tdata[10:3];
        seen.last       = out_tlast;
        if (replies_due.size() == 0) begin
          report_error("result with nothing owed", 32'(seen), 0);
        end else begin
          due = replies_due.pop_front();
          // fields from the top: kind, ok, granted_id, out_byte, last
          if (seen !== due) report_error("result", 32'(seen), 32'(due));
        end
        results_in++;
      end
      if (quiet_left > 0) begin
        quiet_left--;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) == 0) begin
          quiet_left = 80;
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("ring_buffer_pool_history_unit: mismatch");
    $finish;
  end

endmodule
